// ----- rtl/pvna_pkg.sv -----
// ----------------------------------------------------------------------------
// pvna_pkg
// Shared types and constants for the per-vertex normal accumulator.
// ----------------------------------------------------------------------------
package pvna_pkg;

    localparam int MaxVertices = 1024;
    localparam int VaddrBits   = $clog2(MaxVertices);
    localparam int CoordBits   = 16;
    localparam int SumBits     = 48;
    localparam int CountBits   = 16;

    typedef enum logic [1:0] {
        OP_WRITE    = 2'd0,
        OP_TRIANGLE = 2'd1,
        OP_READ     = 2'd2,
        OP_NONE     = 2'd3
    } op_t;

    typedef struct packed {
        op_t                  op;
        logic [9:0]           vertex_index;
        logic signed [15:0]   pos_x;
        logic signed [15:0]   pos_y;
        logic signed [15:0]   pos_z;
        logic [9:0]           corner_a;
        logic [9:0]           corner_b;
        logic [9:0]           corner_c;
    } in_item_t;

    typedef struct packed {
        logic [9:0]           out_index;
        logic signed [15:0]   normal_x;
        logic signed [15:0]   normal_y;
        logic signed [15:0]   normal_z;
        logic [15:0]          faces_touching;
        logic                 degenerate;
    } out_item_t;

    typedef struct packed {
        logic signed [CoordBits-1:0] x;
        logic signed [CoordBits-1:0] y;
        logic signed [CoordBits-1:0] z;
    } pos_entry_t;

    typedef struct packed {
        logic signed [SumBits-1:0] sx;
        logic signed [SumBits-1:0] sy;
        logic signed [SumBits-1:0] sz;
        logic [CountBits-1:0]      count;
    } sum_entry_t;

endpackage

// ----- rtl/pvna_ram.sv -----
// ----------------------------------------------------------------------------
// pvna_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module pvna_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/per_vertex_normal_accumulator.sv -----
// ----------------------------------------------------------------------------
// per_vertex_normal_accumulator
// Accumulates area-weighted face normals per vertex and returns unit normals.
// ----------------------------------------------------------------------------
// After reset the block sweeps the sum memory to zero, one vertex a cycle,
// and holds in_ready low meanwhile. It then takes one beat at a time. A
// triangle passes through three reads of the position memory, a difference
// stage, six products through one shared 17x17 multiplier, and a
// read-modify-write of the sum memory for each corner, done strictly one
// after another so that a corner named twice is summed twice. A read shifts
// the three sum magnitudes right together (0 to 18 times) until the largest
// is below 2^30; the square root then resolves one bit a cycle and the three
// divisions by the length resolve one quotient bit a cycle each. A zero sum
// or an out-of-range vertex returns at once with degenerate set. A finished
// result sits in an output register, so the next beat is accepted while it
// waits.
// ----------------------------------------------------------------------------
module per_vertex_normal_accumulator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  pvna_pkg::in_item_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output pvna_pkg::out_item_t out_data
);

    localparam int AW = pvna_pkg::VaddrBits;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_TRI_RD, S_TRI_MUL, S_ACC_RD, S_ACC_WR,
        S_RD_WAIT, S_NORM, S_SQ, S_SQRT, S_DIV, S_OUT
    } state_t;

    state_t             state_reg;
    logic [5:0]         step_reg;
    logic [1:0]         comp_reg;
    logic [AW-1:0]      clr_addr_reg;
    logic               out_valid_reg;
    pvna_pkg::out_item_t out_data_reg;

    logic [9:0]         corner_reg [3];
    logic [9:0]         vi_reg;
    pvna_pkg::pos_entry_t p_reg [3];
    logic signed [16:0] u_reg [3];
    logic signed [16:0] w_reg [3];
    logic signed [33:0] prod_reg;
    logic signed [34:0] n_reg [3];
    logic [47:0]        t_reg [3];
    logic               neg_reg [3];
    logic [15:0]        count_reg;
    logic [59:0]        sq_reg;
    logic [63:0]        q_reg;
    logic [63:0]        res_reg;
    logic [63:0]        bit_reg;
    logic [47:0]        rem_reg;
    logic [47:0]        den_reg;
    logic [16:0]        quo_reg;
    logic signed [15:0] norm_reg [3];
    logic               degen_reg;

    // Memory ports
    logic                 pos_we;
    logic [AW-1:0]        pos_raddr;
    pvna_pkg::pos_entry_t pos_wdata;
    pvna_pkg::pos_entry_t pos_rdata;
    logic                 sum_we;
    logic [AW-1:0]        sum_waddr;
    logic [AW-1:0]        sum_raddr;
    pvna_pkg::sum_entry_t sum_wdata;
    pvna_pkg::sum_entry_t sum_rdata;

    logic accept;
    logic vi_ok;
    logic tri_ok;
    logic signed [16:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [33:0] mul_p;
    logic [59:0]        sq_p;
    logic [31:0]        len;
    logic [16:0]        mag;
    logic               out_free;

    function automatic logic signed [47:0] sat_add(input logic signed [47:0] s,
                                                   input logic signed [34:0] n);
        logic signed [48:0] r;
        r = 49'(s) + 49'(n);
        if (r[48] != r[47])
        begin
            return r[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end
        return r[47:0];
    endfunction

    function automatic logic [47:0] abs48(input logic signed [47:0] s);
        return s[47] ? 48'(~s + 48'sd1) : 48'(s);
    endfunction

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign vi_ok    = int'(in_data.vertex_index) < pvna_pkg::MaxVertices;
    assign tri_ok   = (int'(in_data.corner_a) < pvna_pkg::MaxVertices)
                   && (int'(in_data.corner_b) < pvna_pkg::MaxVertices)
                   && (int'(in_data.corner_c) < pvna_pkg::MaxVertices);
    assign out_free = !out_valid_reg || out_ready;

    // Position memory: written by vertex-write beats, read by triangles.
    assign pos_we      = accept && (in_data.op == pvna_pkg::OP_WRITE) && vi_ok;
    assign pos_wdata   = '{x: in_data.pos_x, y: in_data.pos_y, z: in_data.pos_z};
    assign pos_raddr   = corner_reg[step_reg[1:0]][AW-1:0];

    pvna_ram #(
        .WIDTH ($bits(pvna_pkg::pos_entry_t)),
        .DEPTH (pvna_pkg::MaxVertices)
    ) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (in_data.vertex_index[AW-1:0]),
        .wdata (pos_wdata),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    // Sum memory: cleared by the sweep and by vertex writes, updated per corner.
    always_comb
    begin
        sum_we    = 1'b0;
        sum_waddr = in_data.vertex_index[AW-1:0];
        sum_wdata = '0;
        sum_raddr = in_data.vertex_index[AW-1:0];
        case (state_reg)
            S_CLEAR:
            begin
                sum_we    = 1'b1;
                sum_waddr = clr_addr_reg;
            end
            S_IDLE:
            begin
                sum_we = pos_we;
            end
            S_ACC_RD:
            begin
                sum_raddr = corner_reg[step_reg[1:0]][AW-1:0];
            end
            S_ACC_WR:
            begin
                sum_we          = 1'b1;
                sum_waddr       = corner_reg[step_reg[1:0]][AW-1:0];
                sum_wdata.sx    = sat_add(sum_rdata.sx, n_reg[0]);
                sum_wdata.sy    = sat_add(sum_rdata.sy, n_reg[1]);
                sum_wdata.sz    = sat_add(sum_rdata.sz, n_reg[2]);
                sum_wdata.count = (sum_rdata.count == 16'hFFFF) ? sum_rdata.count
                                : sum_rdata.count + 16'd1;
            end
            default:
            begin
                sum_we = 1'b0;
            end
        endcase
    end

    pvna_ram #(
        .WIDTH ($bits(pvna_pkg::sum_entry_t)),
        .DEPTH (pvna_pkg::MaxVertices)
    ) u_sum_ram (
        .clk   (clk),
        .we    (sum_we),
        .waddr (sum_waddr),
        .wdata (sum_wdata),
        .raddr (sum_raddr),
        .rdata (sum_rdata)
    );

    // Cross product operands, one product per cycle.
    always_comb
    begin
        case (step_reg[2:0])
            3'd0:    begin mul_a = u_reg[1]; mul_b = w_reg[2]; end
            3'd1:    begin mul_a = u_reg[2]; mul_b = w_reg[1]; end
            3'd2:    begin mul_a = u_reg[2]; mul_b = w_reg[0]; end
            3'd3:    begin mul_a = u_reg[0]; mul_b = w_reg[2]; end
            3'd4:    begin mul_a = u_reg[0]; mul_b = w_reg[1]; end
            3'd5:    begin mul_a = u_reg[1]; mul_b = w_reg[0]; end
            default: begin mul_a = '0;       mul_b = '0;       end
        endcase
    end

    assign mul_p = mul_a * mul_b;
    assign sq_p  = t_reg[step_reg[1:0]][29:0] * t_reg[step_reg[1:0]][29:0];
    assign len   = (res_reg[31:0] == 32'd0) ? 32'd1 : res_reg[31:0];
    assign mag   = (quo_reg > 17'd32767) ? 17'd32767 : quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            step_reg      <= '0;
            comp_reg      <= '0;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // A result waiting in S_OUT reloads the output register itself.
            if (out_valid_reg && out_ready && (state_reg != S_OUT))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == AW'(pvna_pkg::MaxVertices - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    step_reg      <= '0;
                    corner_reg[0] <= in_data.corner_a;
                    corner_reg[1] <= in_data.corner_b;
                    corner_reg[2] <= in_data.corner_c;
                    vi_reg        <= in_data.vertex_index;
                    if (accept)
                    begin
                        case (in_data.op)
                            pvna_pkg::OP_TRIANGLE:
                            begin
                                if (tri_ok)
                                begin
                                    state_reg <= S_TRI_RD;
                                end
                            end
                            pvna_pkg::OP_READ:
                            begin
                                if (vi_ok)
                                begin
                                    state_reg <= S_RD_WAIT;
                                end
                                else
                                begin
                                    // Vertex outside the mesh: zero normal, no faces.
                                    norm_reg[0] <= '0;
                                    norm_reg[1] <= '0;
                                    norm_reg[2] <= '0;
                                    count_reg   <= '0;
                                    degen_reg   <= 1'b1;
                                    state_reg   <= S_OUT;
                                end
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_TRI_RD:
                begin
                    step_reg <= step_reg + 6'd1;
                    if (step_reg >= 6'd1 && step_reg <= 6'd3)
                    begin
                        p_reg[step_reg[1:0] - 2'd1] <= pos_rdata;
                    end
                    if (step_reg == 6'd4)
                    begin
                        u_reg[0]  <= 17'(p_reg[1].x) - 17'(p_reg[0].x);
                        u_reg[1]  <= 17'(p_reg[1].y) - 17'(p_reg[0].y);
                        u_reg[2]  <= 17'(p_reg[1].z) - 17'(p_reg[0].z);
                        w_reg[0]  <= 17'(p_reg[2].x) - 17'(p_reg[1].x);
                        w_reg[1]  <= 17'(p_reg[2].y) - 17'(p_reg[1].y);
                        w_reg[2]  <= 17'(p_reg[2].z) - 17'(p_reg[1].z);
                        step_reg  <= '0;
                        state_reg <= S_TRI_MUL;
                    end
                end
                S_TRI_MUL:
                begin
                    prod_reg <= mul_p;
                    step_reg <= step_reg + 6'd1;
                    if (step_reg != 6'd0)
                    begin
                        if (step_reg[0])
                        begin
                            n_reg[2'((step_reg - 6'd1) >> 1)] <= 35'(prod_reg);
                        end
                        else
                        begin
                            n_reg[2'((step_reg - 6'd1) >> 1)] <=
                                n_reg[2'((step_reg - 6'd1) >> 1)] - 35'(prod_reg);
                        end
                    end
                    if (step_reg == 6'd6)
                    begin
                        step_reg  <= '0;
                        state_reg <= S_ACC_RD;
                    end
                end
                S_ACC_RD:
                begin
                    state_reg <= S_ACC_WR;
                end
                S_ACC_WR:
                begin
                    if (step_reg == 6'd2)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        step_reg  <= step_reg + 6'd1;
                        state_reg <= S_ACC_RD;
                    end
                end
                S_RD_WAIT:
                begin
                    t_reg[0]   <= abs48(sum_rdata.sx);
                    t_reg[1]   <= abs48(sum_rdata.sy);
                    t_reg[2]   <= abs48(sum_rdata.sz);
                    neg_reg[0] <= sum_rdata.sx[47];
                    neg_reg[1] <= sum_rdata.sy[47];
                    neg_reg[2] <= sum_rdata.sz[47];
                    count_reg  <= sum_rdata.count;
                    if (sum_rdata.sx == '0 && sum_rdata.sy == '0 && sum_rdata.sz == '0)
                    begin
                        norm_reg[0] <= '0;
                        norm_reg[1] <= '0;
                        norm_reg[2] <= '0;
                        degen_reg   <= 1'b1;
                        state_reg   <= S_OUT;
                    end
                    else
                    begin
                        degen_reg <= 1'b0;
                        state_reg <= S_NORM;
                    end
                end
                S_NORM:
                begin
                    // Shift all three together until every magnitude fits 30 bits.
                    if (t_reg[0][47:30] != '0 || t_reg[1][47:30] != '0
                        || t_reg[2][47:30] != '0)
                    begin
                        t_reg[0] <= t_reg[0] >> 1;
                        t_reg[1] <= t_reg[1] >> 1;
                        t_reg[2] <= t_reg[2] >> 1;
                    end
                    else
                    begin
                        step_reg  <= '0;
                        state_reg <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    sq_reg   <= sq_p;
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'd0)
                    begin
                        q_reg <= '0;
                    end
                    else
                    begin
                        q_reg <= q_reg + 64'(sq_reg);
                    end
                    if (step_reg == 6'd3)
                    begin
                        res_reg   <= '0;
                        bit_reg   <= 64'd1 << 62;
                        step_reg  <= '0;
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    if (q_reg >= res_reg + bit_reg)
                    begin
                        q_reg   <= q_reg - (res_reg + bit_reg);
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg  <= bit_reg >> 2;
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'd31)
                    begin
                        step_reg  <= '0;
                        comp_reg  <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'd0)
                    begin
                        rem_reg <= ({18'd0, t_reg[comp_reg][29:0]} << 15)
                                 + 48'(len >> 1);
                        den_reg <= 48'(len) << 16;
                        quo_reg <= '0;
                    end
                    else if (step_reg <= 6'd17)
                    begin
                        if (rem_reg >= den_reg)
                        begin
                            rem_reg <= rem_reg - den_reg;
                            quo_reg <= {quo_reg[15:0], 1'b1};
                        end
                        else
                        begin
                            quo_reg <= {quo_reg[15:0], 1'b0};
                        end
                        den_reg <= den_reg >> 1;
                    end
                    else
                    begin
                        norm_reg[comp_reg] <= neg_reg[comp_reg] ? -16'(mag) : 16'(mag);
                        step_reg           <= '0;
                        if (comp_reg == 2'd2)
                        begin
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            comp_reg <= comp_reg + 2'd1;
                        end
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg                <= 1'b1;
                        out_data_reg.out_index       <= vi_reg;
                        out_data_reg.normal_x        <= norm_reg[0];
                        out_data_reg.normal_y        <= norm_reg[1];
                        out_data_reg.normal_z        <= norm_reg[2];
                        out_data_reg.faces_touching  <= count_reg;
                        out_data_reg.degenerate      <= degen_reg;
                        state_reg                    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- sim/tb_per_vertex_normal_accumulator.sv -----
// ----------------------------------------------------------------------------
// tb_per_vertex_normal_accumulator
// Self-checking bench: drives vertex writes, triangles, normal reads and
// unused-op beats with random idling on both channels and checks every read
// against a model of the area-weighted normal sums.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_per_vertex_normal_accumulator;

    // Longest legal silence: the clearing sweep after reset dominates over a
    // worst read and its longest output stall.
    localparam int IdleLimit  = 6000;
    localparam int RandomBeats = 1040;
    localparam longint SumTop = (64'sd1 <<< 47) - 1;
    localparam longint SumBot = -SumTop - 1;

    typedef struct {
        pvna_pkg::in_item_t  beat;
        bit                  literal;
        pvna_pkg::out_item_t want;
    } plan_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    pvna_pkg::in_item_t  in_data = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    pvna_pkg::out_item_t out_data;

    // Shadow of the block's memories.
    pvna_pkg::pos_entry_t vertex_pos [pvna_pkg::MaxVertices];
    longint     acc_x [pvna_pkg::MaxVertices];
    longint     acc_y [pvna_pkg::MaxVertices];
    longint     acc_z [pvna_pkg::MaxVertices];
    int         face_count [pvna_pkg::MaxVertices];
    bit         pos_known [pvna_pkg::MaxVertices];
    int         known_list [$];

    pvna_pkg::out_item_t pending_normals [$];
    plan_row_t  plan [$];
    int         hot_vertex [64];
    int         mismatches = 0;
    int         n_write = 0, n_tri = 0, n_read = 0, n_flat = 0, n_noise = 0;
    int         idle_cycles = 0;

    per_vertex_normal_accumulator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Watchdog: any stretch without a beat on either channel that outlasts
    // the limit means the block has hung.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit)
        begin
            $display("%0t: watchdog expired, %0d results outstanding", $time,
                     pending_normals.size());
            $display("FAIL");
            $finish;
        end
    end

    function automatic longint clamp_sum(longint s);
        if (s > SumTop) return SumTop;
        if (s < SumBot) return SumBot;
        return s;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned q);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > q) b = b >> 2;
        while (b != 0)
        begin
            if (q >= r + b)
            begin
                q = q - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Scales a summed normal to unit length in Q1.15: the sums are shifted
    // down until the largest magnitude is below 2^30, then each component is
    // divided by the integer root of the squared length, rounded to nearest.
    function automatic pvna_pkg::out_item_t unit_normal(logic [9:0] idx);
        pvna_pkg::out_item_t r;
        longint          s [3];
        longint unsigned mag [3];
        longint unsigned peak, len, q;
        int              k;
        r = '0;
        r.out_index = idx;
        r.faces_touching = 16'(face_count[idx]);
        s[0] = acc_x[idx];
        s[1] = acc_y[idx];
        s[2] = acc_z[idx];
        for (int i = 0; i < 3; i++)
            mag[i] = (s[i] < 0) ? longint'(-s[i]) : longint'(s[i]);
        peak = mag[0];
        if (mag[1] > peak) peak = mag[1];
        if (mag[2] > peak) peak = mag[2];
        if (peak == 0)
        begin
            r.degenerate = 1'b1;
            return r;
        end
        k = 0;
        while ((peak >> k) >= (64'd1 << 30)) k++;
        for (int i = 0; i < 3; i++) mag[i] = mag[i] >> k;
        q = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
        len = root_floor(q);
        if (len == 0) len = 1;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = (mag[i] * 32768 + (len >> 1)) / len;
            if (mag[i] > 32767) mag[i] = 32767;
            if (s[i] < 0) mag[i] = -mag[i];
        end
        r.normal_x = mag[0][15:0];
        r.normal_y = mag[1][15:0];
        r.normal_z = mag[2][15:0];
        return r;
    endfunction

    function automatic void add_face(int v, longint nx, longint ny, longint nz);
        acc_x[v] = clamp_sum(acc_x[v] + nx);
        acc_y[v] = clamp_sum(acc_y[v] + ny);
        acc_z[v] = clamp_sum(acc_z[v] + nz);
        if (face_count[v] < 65535) face_count[v]++;
    endfunction

    // Updates the shadow state for one accepted beat and queues the normal a
    // read will return.
    function automatic void track_beat(pvna_pkg::in_item_t b);
        longint ux, uy, uz, wx, wy, wz;
        pvna_pkg::pos_entry_t p0, p1, p2;
        case (b.op)
            pvna_pkg::OP_WRITE:
            begin
                vertex_pos[b.vertex_index] = '{b.pos_x, b.pos_y, b.pos_z};
                acc_x[b.vertex_index] = 0;
                acc_y[b.vertex_index] = 0;
                acc_z[b.vertex_index] = 0;
                face_count[b.vertex_index] = 0;
                if (!pos_known[b.vertex_index]) known_list.push_back(b.vertex_index);
                pos_known[b.vertex_index] = 1'b1;
                n_write++;
            end
            pvna_pkg::OP_TRIANGLE:
            begin
                p0 = vertex_pos[b.corner_a];
                p1 = vertex_pos[b.corner_b];
                p2 = vertex_pos[b.corner_c];
                ux = longint'(p1.x) - longint'(p0.x);
                uy = longint'(p1.y) - longint'(p0.y);
                uz = longint'(p1.z) - longint'(p0.z);
                wx = longint'(p2.x) - longint'(p1.x);
                wy = longint'(p2.y) - longint'(p1.y);
                wz = longint'(p2.z) - longint'(p1.z);
                // Every corner gets the same face normal, a repeated corner
                // once per mention.
                add_face(b.corner_a, uy * wz - uz * wy, uz * wx - ux * wz, ux * wy - uy * wx);
                add_face(b.corner_b, uy * wz - uz * wy, uz * wx - ux * wz, ux * wy - uy * wx);
                add_face(b.corner_c, uy * wz - uz * wy, uz * wx - ux * wz, ux * wy - uy * wx);
                n_tri++;
            end
            pvna_pkg::OP_READ:
            begin
                pending_normals.push_back(unit_normal(b.vertex_index));
                if (pending_normals[$].degenerate) n_flat++;
                n_read++;
            end
            default: n_noise++;
        endcase
    endfunction

    function automatic pvna_pkg::in_item_t make_beat(pvna_pkg::op_t op, int idx, int x,
                                                     int y, int z, int a, int b, int c);
        pvna_pkg::in_item_t r;
        r.op = op;
        r.vertex_index = 10'(idx);
        r.pos_x = 16'(x);
        r.pos_y = 16'(y);
        r.pos_z = 16'(z);
        r.corner_a = 10'(a);
        r.corner_b = 10'(b);
        r.corner_c = 10'(c);
        return r;
    endfunction

    function automatic void plan_row(pvna_pkg::in_item_t b);
        plan_row_t r;
        r.beat = b;
        r.literal = 1'b0;
        r.want = '0;
        plan.push_back(r);
    endfunction

    function automatic void plan_known(pvna_pkg::in_item_t b, pvna_pkg::out_item_t want);
        plan_row_t r;
        r.beat = b;
        r.literal = 1'b1;
        r.want = want;
        plan.push_back(r);
    endfunction

    function automatic int draw_coord();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 1) ? 32767 : -32768;
            1: return int'($urandom) % 65536;
            default: return $urandom_range(0, 4095) - 2048;
        endcase
    endfunction

    function automatic int pick_known();
        return known_list[$urandom_range(0, known_list.size() - 1)];
    endfunction

    // Random beat: mostly writes and triangles on a pool of hot vertices so
    // that reads see sums built from several faces, plus some noise.
    function automatic pvna_pkg::in_item_t draw_beat();
        pvna_pkg::in_item_t r;
        int       roll;
        int       idx;
        r = make_beat(pvna_pkg::OP_NONE, $urandom_range(0, 1023), $urandom, $urandom,
                      $urandom, $urandom_range(0, 1023), $urandom_range(0, 1023),
                      $urandom_range(0, 1023));
        roll = $urandom_range(0, 99);
        idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                          : hot_vertex[$urandom_range(0, 63)];
        if (roll < 22)
        begin
            r.op = pvna_pkg::OP_WRITE;
            r.vertex_index = 10'(idx);
            r.pos_x = 16'(draw_coord());
            r.pos_y = 16'(draw_coord());
            r.pos_z = 16'(draw_coord());
        end
        else if (roll < 70)
        begin
            r.op = pvna_pkg::OP_TRIANGLE;
            r.corner_a = 10'(pick_known());
            r.corner_b = 10'(pick_known());
            r.corner_c = 10'(pick_known());
        end
        else if (roll < 95)
        begin
            r.op = pvna_pkg::OP_READ;
            r.vertex_index = 10'($urandom_range(0, 2) != 0 ? pick_known() : idx);
        end
        return r;
    endfunction

    // Result side: random back-pressure, with occasional runs of none.
    initial
    begin
        int        stall;
        int        calm;
        pvna_pkg::out_item_t want;
        calm = 0;
        @(posedge clk);
        forever
        begin
            if (calm > 0)
                calm--;
            else if ($urandom_range(0, 15) == 0)
                calm = $urandom_range(10, 30);
            stall = (calm > 0) ? 0 : $urandom_range(0, 10);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            if (pending_normals.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %p", $time,
                         out_data);
                mismatches++;
            end
            else
            begin
                want = pending_normals.pop_front();
                if (out_data.out_index !== want.out_index)
                    $display("%0t: out_index expected %0d actual %0d", $time,
                             want.out_index, out_data.out_index);
                if (out_data.normal_x !== want.normal_x)
                    $display("%0t: normal_x expected %0d actual %0d", $time,
                             want.normal_x, out_data.normal_x);
                if (out_data.normal_y !== want.normal_y)
                    $display("%0t: normal_y expected %0d actual %0d", $time,
                             want.normal_y, out_data.normal_y);
                if (out_data.normal_z !== want.normal_z)
                    $display("%0t: normal_z expected %0d actual %0d", $time,
                             want.normal_z, out_data.normal_z);
                if (out_data.faces_touching !== want.faces_touching)
                    $display("%0t: faces_touching expected %0d actual %0d", $time,
                             want.faces_touching, out_data.faces_touching);
                if (out_data.degenerate !== want.degenerate)
                    $display("%0t: degenerate expected %0d actual %0d", $time,
                             want.degenerate, out_data.degenerate);
                if (out_data !== want) mismatches++;
            end
        end
    end

    // Stimulus side and end of run.
    initial
    begin
        pvna_pkg::in_item_t beat;
        int       gap;
        int       calm;
        int       total;
        for (int v = 0; v < pvna_pkg::MaxVertices; v++)
        begin
            acc_x[v] = 0;
            acc_y[v] = 0;
            acc_z[v] = 0;
            face_count[v] = 0;
            pos_known[v] = 1'b0;
            vertex_pos[v] = '0;
        end
        for (int i = 0; i < 64; i++) hot_vertex[i] = $urandom_range(0, 1023);

        // Directed rows: an isosceles right triangle whose normal points
        // straight up, coordinate extremes at the top of the index range,
        // repeated corners, an untouched vertex and the unused op code.
        plan_row(make_beat(pvna_pkg::OP_WRITE, 0, 0, 0, 0, 0, 0, 0));
        plan_row(make_beat(pvna_pkg::OP_WRITE, 1, 256, 0, 0, 0, 0, 0));
        plan_row(make_beat(pvna_pkg::OP_WRITE, 2, 0, 256, 0, 0, 0, 0));
        plan_known(make_beat(pvna_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0),
                   '{10'd0, 0, 0, 0, 0, 1'b1});
        plan_known(make_beat(pvna_pkg::OP_READ, 500, 0, 0, 0, 0, 0, 0),
                   '{10'd500, 0, 0, 0, 0, 1'b1});
        plan_row(make_beat(pvna_pkg::OP_TRIANGLE, 0, 0, 0, 0, 0, 1, 2));
        plan_known(make_beat(pvna_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0),
                   '{10'd0, 16'sd0, 16'sd0, 16'sd32767, 16'd1, 1'b0});
        plan_row(make_beat(pvna_pkg::OP_TRIANGLE, 0, 0, 0, 0, 0, 0, 1));
        plan_row(make_beat(pvna_pkg::OP_TRIANGLE, 0, 0, 0, 0, 2, 1, 1));
        plan_row(make_beat(pvna_pkg::OP_READ, 1, 0, 0, 0, 0, 0, 0));
        plan_row(make_beat(pvna_pkg::OP_READ, 2, 0, 0, 0, 0, 0, 0));
        plan_row(make_beat(pvna_pkg::OP_WRITE, 1023, -32768, -32768, -32768, 0, 0, 0));
        plan_row(make_beat(pvna_pkg::OP_WRITE, 1022, 32767, 32767, 32767, 0, 0, 0));
        plan_row(make_beat(pvna_pkg::OP_WRITE, 1021, 32767, -32768, 0, 0, 0, 0));
        plan_row(make_beat(pvna_pkg::OP_WRITE, 768, -32768, 32767, 32767, 0, 0, 0));
        plan_row(make_beat(pvna_pkg::OP_TRIANGLE, 0, 0, 0, 0, 1021, 1022, 1023));
        plan_row(make_beat(pvna_pkg::OP_TRIANGLE, 0, 0, 0, 0, 1023, 768, 1021));
        plan_row(make_beat(pvna_pkg::OP_TRIANGLE, 0, 0, 0, 0, 1022, 1023, 768));
        plan_row(make_beat(pvna_pkg::OP_READ, 1023, 0, 0, 0, 0, 0, 0));
        plan_row(make_beat(pvna_pkg::OP_READ, 1021, 0, 0, 0, 0, 0, 0));
        plan_row(make_beat(pvna_pkg::OP_READ, 768, 0, 0, 0, 0, 0, 0));
        plan_row(make_beat(pvna_pkg::OP_NONE, 1023, -1, -1, -1, 1023, 1023, 1023));
        plan_row(make_beat(pvna_pkg::OP_WRITE, 1021, 512, 512, 512, 0, 0, 0));
        plan_known(make_beat(pvna_pkg::OP_READ, 1021, 0, 0, 0, 0, 0, 0),
                   '{10'd1021, 0, 0, 0, 0, 1'b1});

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        calm = 0;
        total = plan.size() + RandomBeats;
        for (int n = 0; n < total; n++)
        begin
            if (n < plan.size())
                beat = plan[n].beat;
            else
                beat = draw_beat();
            // Once, let the block drain completely before carrying on.
            if (n == plan.size() + RandomBeats / 2)
            begin
                in_valid <= 1'b0;
                do @(posedge clk); while (pending_normals.size() != 0);
            end
            if (calm > 0)
                calm--;
            else if ($urandom_range(0, 15) == 0)
                calm = $urandom_range(10, 30);
            gap = (calm > 0) ? 0 : $urandom_range(0, 10);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid <= 1'b1;
            in_data <= beat;
            do @(posedge clk); while (!in_ready);
            track_beat(beat);
            if (n < plan.size() && plan[n].literal)
            begin
                void'(pending_normals.pop_back());
                pending_normals.push_back(plan[n].want);
            end
        end
        in_valid <= 1'b0;

        while (pending_normals.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);

        $display("Covered %0d vertex writes, %0d triangles, %0d normal reads", n_write,
                 n_tri, n_read);
        $display("(%0d of them degenerate) and %0d unused-op beats.", n_flat, n_noise);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/pvna_pkg.sv
rtl/pvna_ram.sv
rtl/per_vertex_normal_accumulator.sv
sim/tb_per_vertex_normal_accumulator.sv
